FILE: rtl/hsvci_pkg.sv
package hsvci_pkg;

  localparam logic [1:0] HUE_CW   = 2'd0;
  localparam logic [1:0] HUE_CCW  = 2'd1;
  localparam logic [1:0] HUE_AUTO = 2'd2;

  localparam logic [7:0] HALF_TURN = 8'd128;

  localparam int NUM_LANES = 3;
  localparam int LANE_HUE  = 0;
  localparam int LANE_SAT  = 1;
  localparam int LANE_VAL  = 2;

  typedef struct packed {
    logic [7:0] base;
    logic [7:0] mag;
    logic       neg;
  } lane_op_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } color_t;

endpackage

FILE: rtl/hsvci_if.sv
interface hsvci_in_if #(parameter int TICK_WIDTH = 31);
  logic                  valid;
  logic                  ready;
  logic [7:0]            start_hue;
  logic [7:0]            start_sat;
  logic [7:0]            start_val;
  logic [7:0]            end_hue;
  logic [7:0]            end_sat;
  logic [7:0]            end_val;
  logic [1:0]            func;
  logic [TICK_WIDTH-1:0] start_time;
  logic [TICK_WIDTH-1:0] end_time;
  logic [TICK_WIDTH-1:0] now_time;

  modport source (
    output valid, start_hue, start_sat, start_val, end_hue, end_sat, end_val,
           func, start_time, end_time, now_time,
    input  ready
  );

  modport sink (
    input  valid, start_hue, start_sat, start_val, end_hue, end_sat, end_val,
           func, start_time, end_time, now_time,
    output ready
  );
endinterface

interface hsvci_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_hue;
  logic [7:0] out_sat;
  logic [7:0] out_val;

  modport source (output valid, out_hue, out_sat, out_val, input ready);
  modport sink (input valid, out_hue, out_sat, out_val, output ready);
endinterface

FILE: rtl/hsvci_prep.sv
module hsvci_prep #(
  parameter int TICK_WIDTH = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  hsvci_in_if.sink              fade,
  output logic                  vld,
  output hsvci_pkg::lane_op_t   ops [hsvci_pkg::NUM_LANES],
  output logic [TICK_WIDTH-1:0] off_mag,
  output logic [TICK_WIDTH-1:0] div
);

  logic                  finished;
  logic                  off_neg;
  logic                  span_neg;
  logic                  zero_span;
  logic                  t_neg;
  logic                  hue_cw;
  logic                  hue_ok;
  logic                  sat_dn;
  logic                  val_dn;
  logic [7:0]            hue_fwd;
  logic [7:0]            hue_back;
  logic [TICK_WIDTH-1:0] off_mag_next;
  logic [TICK_WIDTH-1:0] div_next;
  hsvci_pkg::lane_op_t   ops_next [hsvci_pkg::NUM_LANES];

  assign fade.ready = en;

  always_comb begin
    finished  = fade.now_time >= fade.end_time;
    off_neg   = fade.now_time < fade.start_time;
    span_neg  = fade.end_time < fade.start_time;
    zero_span = fade.end_time == fade.start_time;
    t_neg     = off_neg ^ span_neg;

    off_mag_next = off_neg ? (fade.start_time - fade.now_time)
                           : (fade.now_time - fade.start_time);
    div_next     = span_neg ? (fade.start_time - fade.end_time)
                            : (fade.end_time - fade.start_time);
    // A zero-length span divides a zero product by one.
    div_next[0]  = div_next[0] | zero_span;

    hue_fwd  = fade.end_hue - fade.start_hue;
    hue_back = fade.start_hue - fade.end_hue;
    hue_cw   = 1'b1;
    hue_ok   = 1'b1;
    unique case (fade.func)
      hsvci_pkg::HUE_CW: begin
        hue_cw = 1'b1;
      end
      hsvci_pkg::HUE_CCW: begin
        hue_cw = 1'b0;
      end
      hsvci_pkg::HUE_AUTO: begin
        hue_cw = hue_fwd <= hsvci_pkg::HALF_TURN;
      end
      default: begin
        hue_ok = 1'b0;
      end
    endcase

    sat_dn = fade.end_sat < fade.start_sat;
    val_dn = fade.end_val < fade.start_val;

    ops_next[hsvci_pkg::LANE_HUE] = '{base: fade.start_hue,
                                      mag:  hue_cw ? hue_fwd : hue_back,
                                      neg:  !hue_cw ^ t_neg};
    ops_next[hsvci_pkg::LANE_SAT] = '{base: fade.start_sat,
                                      mag:  sat_dn ? (fade.start_sat - fade.end_sat)
                                                   : (fade.end_sat - fade.start_sat),
                                      neg:  sat_dn ^ t_neg};
    ops_next[hsvci_pkg::LANE_VAL] = '{base: fade.start_val,
                                      mag:  val_dn ? (fade.start_val - fade.end_val)
                                                   : (fade.end_val - fade.start_val),
                                      neg:  val_dn ^ t_neg};

    if (!hue_ok) begin
      ops_next[hsvci_pkg::LANE_HUE] = '0;
    end
    if (finished || zero_span) begin
      for (int k = 0; k < hsvci_pkg::NUM_LANES; k++) begin
        ops_next[k].mag = '0;
      end
    end
    if (finished) begin
      ops_next[hsvci_pkg::LANE_HUE].base = fade.end_hue;
      ops_next[hsvci_pkg::LANE_SAT].base = fade.end_sat;
      ops_next[hsvci_pkg::LANE_VAL].base = fade.end_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= fade.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops     <= ops_next;
      off_mag <= off_mag_next;
      div     <= div_next;
    end
  end

endmodule

FILE: rtl/hsvci_lane.sv
module hsvci_lane #(
  parameter int TICK_WIDTH = 31
) (
  input  logic                  clk,
  input  logic                  en,
  input  hsvci_pkg::lane_op_t   op,
  input  logic [TICK_WIDTH-1:0] off_mag,
  input  logic [TICK_WIDTH-1:0] div_in,
  output logic [7:0]            result
);

  localparam int NUM_WIDTH = TICK_WIDTH + 8;

  logic [TICK_WIDTH-1:0] rem   [NUM_WIDTH];
  logic [NUM_WIDTH-1:0]  num   [NUM_WIDTH];
  logic [TICK_WIDTH-1:0] dvs   [NUM_WIDTH];
  logic [7:0]            quo   [NUM_WIDTH+1];
  logic [7:0]            base  [NUM_WIDTH+1];
  logic                  neg   [NUM_WIDTH+1];
  logic [TICK_WIDTH:0]   trial [NUM_WIDTH];
  logic [TICK_WIDTH:0]   diff  [NUM_WIDTH];
  logic                  take  [NUM_WIDTH];
  logic [7:0]            q_signed;

  always_comb begin
    for (int k = 0; k < NUM_WIDTH; k++) begin
      trial[k] = {rem[k], num[k][NUM_WIDTH-1]};
      diff[k]  = trial[k] - {1'b0, dvs[k]};
      take[k]  = trial[k] >= {1'b0, dvs[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      num[0]  <= NUM_WIDTH'(op.mag) * NUM_WIDTH'(off_mag);
      dvs[0]  <= div_in;
      quo[0]  <= '0;
      base[0] <= op.base;
      neg[0]  <= op.neg;
      for (int k = 0; k < NUM_WIDTH - 1; k++) begin
        rem[k+1] <= take[k] ? diff[k][TICK_WIDTH-1:0] : trial[k][TICK_WIDTH-1:0];
        num[k+1] <= num[k] << 1;
        dvs[k+1] <= dvs[k];
      end
      for (int k = 0; k < NUM_WIDTH; k++) begin
        quo[k+1]  <= {quo[k][6:0], take[k]};
        base[k+1] <= base[k];
        neg[k+1]  <= neg[k];
      end
    end
  end

  always_comb begin
    q_signed = neg[NUM_WIDTH] ? (~quo[NUM_WIDTH] + 8'd1) : quo[NUM_WIDTH];
    result   = base[NUM_WIDTH] + q_signed;
  end

endmodule

FILE: rtl/hsvci_merge.sv
module hsvci_merge (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  lane_res [hsvci_pkg::NUM_LANES],
  output logic        en,
  hsvci_out_if.source color
);

  hsvci_pkg::color_t res_c;
  hsvci_pkg::color_t out_c;
  hsvci_pkg::color_t skid_c;
  logic              out_valid;
  logic              skid_valid;
  logic              load;

  assign res_c = '{hue: lane_res[hsvci_pkg::LANE_HUE],
                   sat: lane_res[hsvci_pkg::LANE_SAT],
                   val: lane_res[hsvci_pkg::LANE_VAL]};
  assign en    = !skid_valid;
  assign load  = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && color.ready) begin
      if (skid_valid) begin
        out_c      <= skid_c;
        skid_valid <= 1'b0;
      end else if (load) begin
        out_c <= res_c;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (load) begin
        out_c     <= res_c;
        out_valid <= 1'b1;
      end
    end else if (load) begin
      skid_c     <= res_c;
      skid_valid <= 1'b1;
    end
  end

  assign color.valid   = out_valid;
  assign color.out_hue = out_c.hue;
  assign color.out_sat = out_c.sat;
  assign color.out_val = out_c.val;

endmodule

FILE: rtl/hsv_color_time_interpolator_core.sv
// HSV color fade evaluator.
// The fade channel carries one item per evaluation: start and end colors, the hue
// path selector and three tick times. The color channel returns one item per fade
// item, in order, with the color at now_time.
// Both channels use valid/ready; an item moves when both are high at a clock edge.
// The quotient is formed by a pipelined restoring divider with one quotient bit per
// stage over the TICK_WIDTH + 8 bit product. Throughput is one item per cycle while
// the pipeline is not held. The hue, saturation and value lanes run side by side
// and their results are joined in an output register with a skid entry.
// When the receiver stalls, the output holds and one more item still lands in the
// skid entry; after that, fade.ready drops and the whole pipeline holds until the
// output is taken.
// Synchronous reset empties the pipeline and the output; no state survives between
// items, so no startup sweep is needed.
module hsv_color_time_interpolator_core #(
  parameter int TICK_WIDTH = 31
) (
  input  logic        clk,
  input  logic        rst,
  hsvci_in_if.sink    fade,
  hsvci_out_if.source color
);

  localparam int NUM_WIDTH = TICK_WIDTH + 8;

  logic                  en;
  logic                  prep_vld;
  hsvci_pkg::lane_op_t   ops [hsvci_pkg::NUM_LANES];
  logic [TICK_WIDTH-1:0] off_mag;
  logic [TICK_WIDTH-1:0] div;
  logic [7:0]            lane_res [hsvci_pkg::NUM_LANES];
  logic [NUM_WIDTH:0]    vld;

  hsvci_prep #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .fade    (fade),
    .vld     (prep_vld),
    .ops     (ops),
    .off_mag (off_mag),
    .div     (div)
  );

  for (genvar g = 0; g < hsvci_pkg::NUM_LANES; g++) begin : g_lane
    hsvci_lane #(
      .TICK_WIDTH (TICK_WIDTH)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .op      (ops[g]),
      .off_mag (off_mag),
      .div_in  (div),
      .result  (lane_res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_WIDTH-1:0], prep_vld};
    end
  end

  hsvci_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[NUM_WIDTH]),
    .lane_res (lane_res),
    .en       (en),
    .color    (color)
  );

endmodule

FILE: rtl/hsvci_checker.sv
module hsvci_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_hue,
  input logic [7:0] out_sat,
  input logic [7:0] out_val
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({out_hue, out_sat, out_val}))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result item present right after reset");

  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input blocked with no result waiting");

  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input blocked without an output stall");

endmodule

bind hsv_color_time_interpolator_core hsvci_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (fade.ready),
  .out_valid (color.valid),
  .out_ready (color.ready),
  .out_hue   (color.out_hue),
  .out_sat   (color.out_sat),
  .out_val   (color.out_val)
);

FILE: tb/hsv_color_time_interpolator_core_tb.sv
module hsv_color_time_interpolator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = 31;
  localparam logic [TW-1:0] TICK_MAX = '1;
  localparam logic [1:0] HUE_BAD = 2'd3;
  localparam longint FULL_TURN = 256;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    hsvci_pkg::color_t start_c;
    hsvci_pkg::color_t end_c;
    logic [1:0]        func;
    logic [TW-1:0]     start_time;
    logic [TW-1:0]     end_time;
    logic [TW-1:0]     now_time;
  } fade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hsvci_in_if #(.TICK_WIDTH(TW)) fade_if ();
  hsvci_out_if color_if ();

  hsv_color_time_interpolator_core #(.TICK_WIDTH(TW)) DUT (
    .clk(clk),
    .rst(rst),
    .fade(fade_if),
    .color(color_if)
  );

  hsvci_pkg::color_t expected_colors[$];
  int     mismatches = 0;
  int     fades_sent = 0;
  int     colors_checked = 0;
  int     cycle_count = 0;
  bit     fade_gaps_on = 1'b1;
  bit     color_stalls_on = 1'b1;
  int     color_hold_cycles = 0;

  function automatic logic [7:0] blend8(longint a, longint b, longint ts, longint te,
                                        longint tn);
    longint span, off, r;
    span = te - ts;
    off  = tn - ts;
    if (span == 0) begin
      r = a;
    end else begin
      r = a + ((b - a) * off) / span;
    end
    return r[7:0];
  endfunction

  function automatic hsvci_pkg::color_t fade_color(fade_t f);
    hsvci_pkg::color_t c;
    logic [1:0]        path;
    longint            sh, eh, ts, te, tn;
    if (f.now_time >= f.end_time) begin
      return f.end_c;
    end
    sh = longint'(f.start_c.hue);
    eh = longint'(f.end_c.hue);
    ts = longint'(f.start_time);
    te = longint'(f.end_time);
    tn = longint'(f.now_time);
    path = f.func;
    if (path == hsvci_pkg::HUE_AUTO) begin
      if (sh < eh) begin
        path = ((eh - sh) <= hsvci_pkg::HALF_TURN) ? hsvci_pkg::HUE_CW : hsvci_pkg::HUE_CCW;
      end else if (sh > eh) begin
        path = ((sh - eh) >= hsvci_pkg::HALF_TURN) ? hsvci_pkg::HUE_CW : hsvci_pkg::HUE_CCW;
      end else begin
        path = hsvci_pkg::HUE_CW;
      end
    end
    case (path)
      hsvci_pkg::HUE_CW: begin
        c.hue = blend8(sh, (eh < sh) ? eh + FULL_TURN : eh, ts, te, tn);
      end
      hsvci_pkg::HUE_CCW: begin
        c.hue = blend8((sh < eh) ? sh + FULL_TURN : sh, eh, ts, te, tn);
      end
      default: begin
        c.hue = 8'd0;
      end
    endcase
    c.sat = blend8(longint'(f.start_c.sat), longint'(f.end_c.sat), ts, te, tn);
    c.val = blend8(longint'(f.start_c.val), longint'(f.end_c.val), ts, te, tn);
    return c;
  endfunction

  function automatic fade_t mk_fade(logic [7:0] sh, logic [7:0] ss, logic [7:0] sv,
                                    logic [7:0] eh, logic [7:0] es, logic [7:0] ev,
                                    logic [1:0] func, logic [TW-1:0] ts,
                                    logic [TW-1:0] te, logic [TW-1:0] tn);
    fade_t f;
    f.start_c.hue = sh;
    f.start_c.sat = ss;
    f.start_c.val = sv;
    f.end_c.hue   = eh;
    f.end_c.sat   = es;
    f.end_c.val   = ev;
    f.func        = func;
    f.start_time  = ts;
    f.end_time    = te;
    f.now_time    = tn;
    return f;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = 8'h00;
      1: b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic logic [TW-1:0] rand_tick();
    logic [TW-1:0] t;
    t = TW'($urandom);
    return t;
  endfunction

  function automatic fade_t random_fade();
    fade_t         f;
    logic [TW-1:0] span;
    f.start_c.hue = pick_byte();
    f.start_c.sat = pick_byte();
    f.start_c.val = pick_byte();
    f.end_c.hue   = pick_byte();
    f.end_c.sat   = pick_byte();
    f.end_c.val   = pick_byte();
    f.func        = 2'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0: begin
        f.start_time = rand_tick();
        f.end_time   = rand_tick();
        f.now_time   = rand_tick();
      end
      1: begin
        f.start_time = rand_tick();
        f.end_time   = f.start_time;
        f.now_time   = rand_tick();
      end
      2: begin
        f.start_time = TW'($urandom_range(0, 255));
        f.end_time   = TW'(TICK_MAX - $urandom_range(0, 255));
        f.now_time   = rand_tick();
      end
      default: begin
        span         = TW'($urandom_range(1, 3000));
        f.start_time = rand_tick();
        f.end_time   = f.start_time + span;
        f.now_time   = TW'(f.start_time - 200 + $urandom_range(0, span + 400));
      end
    endcase
    return f;
  endfunction

  task automatic send_fade(input fade_t f);
    int gap;
    gap = fade_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      fade_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    fade_if.start_hue  <= f.start_c.hue;
    fade_if.start_sat  <= f.start_c.sat;
    fade_if.start_val  <= f.start_c.val;
    fade_if.end_hue    <= f.end_c.hue;
    fade_if.end_sat    <= f.end_c.sat;
    fade_if.end_val    <= f.end_c.val;
    fade_if.func       <= f.func;
    fade_if.start_time <= f.start_time;
    fade_if.end_time   <= f.end_time;
    fade_if.now_time   <= f.now_time;
    fade_if.valid      <= 1'b1;
    @(posedge clk);
    while (!fade_if.ready) @(posedge clk);
    expected_colors.push_back(fade_color(f));
    fades_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_colors();
    fade_if.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_corner_cases();
    fade_gaps_on    = 1'b1;
    color_stalls_on = 1'b1;
    send_fade(mk_fade(0, 0, 0, 0, 0, 0, hsvci_pkg::HUE_CW, 0, 0, 0));
    send_fade(mk_fade(255, 255, 255, 0, 0, 0, hsvci_pkg::HUE_CW, 0, TICK_MAX,
                      TICK_MAX - 1'b1));
    send_fade(mk_fade(0, 0, 0, 255, 255, 255, hsvci_pkg::HUE_CCW, 0, TICK_MAX,
                      TICK_MAX - 1'b1));
    send_fade(mk_fade(12, 34, 56, 200, 210, 220, hsvci_pkg::HUE_AUTO, 100, 200, TICK_MAX));
    send_fade(mk_fade(200, 10, 250, 10, 250, 10, hsvci_pkg::HUE_CW, 0, 100, 50));
    send_fade(mk_fade(10, 250, 10, 200, 10, 250, hsvci_pkg::HUE_CCW, 0, 100, 50));
    send_fade(mk_fade(0, 1, 2, 128, 3, 4, hsvci_pkg::HUE_AUTO, 0, 64, 16));
    send_fade(mk_fade(128, 1, 2, 0, 3, 4, hsvci_pkg::HUE_AUTO, 0, 64, 16));
    send_fade(mk_fade(77, 0, 255, 77, 255, 0, hsvci_pkg::HUE_AUTO, 0, 64, 16));
    send_fade(mk_fade(10, 9, 8, 137, 7, 6, hsvci_pkg::HUE_AUTO, 0, 10, 3));
    send_fade(mk_fade(10, 9, 8, 139, 7, 6, hsvci_pkg::HUE_AUTO, 0, 10, 3));
    send_fade(mk_fade(137, 9, 8, 10, 7, 6, hsvci_pkg::HUE_AUTO, 0, 10, 3));
    send_fade(mk_fade(139, 9, 8, 10, 7, 6, hsvci_pkg::HUE_AUTO, 0, 10, 3));
    send_fade(mk_fade(10, 20, 30, 250, 240, 230, hsvci_pkg::HUE_CW, 1000, 2000, 0));
    send_fade(mk_fade(255, 0, 255, 0, 255, 0, hsvci_pkg::HUE_CCW, TICK_MAX - 3'd5,
                      TICK_MAX, 0));
    send_fade(mk_fade(40, 50, 60, 70, 80, 90, hsvci_pkg::HUE_AUTO, 500, 500, 100));
    send_fade(mk_fade(40, 50, 60, 70, 80, 90, hsvci_pkg::HUE_CW, TICK_MAX, TICK_MAX, 0));
    send_fade(mk_fade(90, 100, 110, 5, 6, 7, HUE_BAD, 0, 100, 30));
    send_fade(mk_fade(90, 100, 110, 5, 6, 7, HUE_BAD, 0, 100, 100));
    send_fade(mk_fade(30, 60, 90, 220, 20, 200, hsvci_pkg::HUE_CCW, TICK_MAX, 10, 0));
    send_fade(mk_fade(30, 60, 90, 220, 20, 200, hsvci_pkg::HUE_CW, 40, 41, 40));
  endtask

  task automatic test_random_fades(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        fade_gaps_on    = ($urandom_range(0, 3) != 0);
        color_stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_fade(random_fade());
    end
  endtask

  task automatic test_back_to_back(input int count);
    fade_gaps_on    = 1'b0;
    color_stalls_on = 1'b0;
    repeat (count) send_fade(random_fade());
  endtask

  task automatic test_output_backpressure(input int count);
    fade_gaps_on      = 1'b0;
    color_stalls_on   = 1'b0;
    color_hold_cycles = 400;
    repeat (count) send_fade(random_fade());
    wait_for_colors();
  endtask

  task automatic test_drain_pauses();
    fade_gaps_on    = 1'b1;
    color_stalls_on = 1'b1;
    repeat (4) begin
      repeat (20) send_fade(random_fade());
      wait_for_colors();
    end
  endtask

  initial begin : color_sink
    int stall;
    color_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (color_hold_cycles > 0) begin
        color_if.ready <= 1'b0;
        repeat (color_hold_cycles) @(negedge clk);
        color_hold_cycles = 0;
      end
      stall = color_stalls_on ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        color_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      color_if.ready <= 1'b1;
      @(posedge clk);
      while (!(color_if.valid && color_if.ready) && color_hold_cycles == 0) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic void compare_lane(string lane, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, lane, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : color_check
    hsvci_pkg::color_t want;
    if (!rst && color_if.valid && color_if.ready) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: color item with none expected, expected none, actual %0d/%0d/%0d",
                 $time, color_if.out_hue, color_if.out_sat, color_if.out_val);
        mismatches++;
      end else begin
        want = expected_colors.pop_front();
        compare_lane("out_hue", want.hue, color_if.out_hue);
        compare_lane("out_sat", want.sat, color_if.out_sat);
        compare_lane("out_val", want.val, color_if.out_val);
        colors_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d colors outstanding.", cycle_count,
               expected_colors.size());
      $display("hsv_color_time_interpolator_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    fade_if.valid      = 1'b0;
    fade_if.start_hue  = '0;
    fade_if.start_sat  = '0;
    fade_if.start_val  = '0;
    fade_if.end_hue    = '0;
    fade_if.end_sat    = '0;
    fade_if.end_val    = '0;
    fade_if.func       = hsvci_pkg::HUE_CW;
    fade_if.start_time = '0;
    fade_if.end_time   = '0;
    fade_if.now_time   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_random_fades(700);
    test_back_to_back(150);
    test_output_backpressure(120);
    test_drain_pauses();
    wait_for_colors();
    repeat (TW + 20) @(posedge clk);
    $display("Covered hue paths, fade edges, extrapolation, idle gaps, stalls and drains.");
    $display("%0d fades sent, %0d colors checked, %0d mismatches.", fades_sent,
             colors_checked, mismatches);
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("hsv_color_time_interpolator_core_tb OK");
    end else begin
      $display("hsv_color_time_interpolator_core_tb NOT OK");
    end
    $finish;
  end

endmodule
